// ===== rtl/afu_pkg.sv =====
// Package: operation codes, flag positions and transaction types of the ALU flag unit.
package afu_pkg;

	// Operation codes
	localparam logic [5:0] OP_ADD    = 6'd0;
	localparam logic [5:0] OP_ADC    = 6'd1;
	localparam logic [5:0] OP_SUB    = 6'd2;
	localparam logic [5:0] OP_SBC    = 6'd3;
	localparam logic [5:0] OP_AND    = 6'd4;
	localparam logic [5:0] OP_XOR    = 6'd5;
	localparam logic [5:0] OP_OR     = 6'd6;
	localparam logic [5:0] OP_CP     = 6'd7;
	localparam logic [5:0] OP_RLC    = 6'd8;
	localparam logic [5:0] OP_SRL    = 6'd15;
	localparam logic [5:0] OP_RLCA   = 6'd16;
	localparam logic [5:0] OP_RRA    = 6'd19;
	localparam logic [5:0] OP_BIT    = 6'd20;
	localparam logic [5:0] OP_RES    = 6'd21;
	localparam logic [5:0] OP_SET    = 6'd22;
	localparam logic [5:0] OP_DAA    = 6'd23;
	localparam logic [5:0] OP_CPL    = 6'd24;
	localparam logic [5:0] OP_SCF    = 6'd25;
	localparam logic [5:0] OP_CCF    = 6'd26;
	localparam logic [5:0] OP_INC8   = 6'd27;
	localparam logic [5:0] OP_DEC8   = 6'd28;
	localparam logic [5:0] OP_ADD16  = 6'd29;
	localparam logic [5:0] OP_ADDOFS = 6'd30;
	localparam logic [5:0] OP_INC16  = 6'd31;
	localparam logic [5:0] OP_DEC16  = 6'd32;

	// Accumulator ALU kinds, taken from the low three bits of the code
	localparam logic [2:0] AL_ADD = 3'd0;
	localparam logic [2:0] AL_ADC = 3'd1;
	localparam logic [2:0] AL_SUB = 3'd2;
	localparam logic [2:0] AL_SBC = 3'd3;
	localparam logic [2:0] AL_AND = 3'd4;
	localparam logic [2:0] AL_XOR = 3'd5;
	localparam logic [2:0] AL_OR  = 3'd6;
	localparam logic [2:0] AL_CP  = 3'd7;

	// Rotate and shift kinds, taken from the low three bits of the code
	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	// Flag bit positions in the packed Z N H C nibble
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [5:0]        req_type;
		logic [7:0]        acc_value;
		logic [7:0]        operand_value;
		logic [15:0]       wide_left;
		logic [15:0]       wide_right;
		logic signed [7:0] signed_offset;
		logic [2:0]        bit_index;
		logic [3:0]        flags_in;
	} req_t;

	typedef struct packed {
		logic [7:0]  result_byte;
		logic [15:0] result_word;
		logic [3:0]  flags_out;
	} rsp_t;

endpackage

// ===== rtl/afu_core.sv =====
// Combinational datapath: computes result byte, result word and flags of one operation.
module afu_core (
	input  afu_pkg::req_t req,
	output afu_pkg::rsp_t rsp
);
	import afu_pkg::*;

	logic [7:0]  a;
	logic [7:0]  v;
	logic [3:0]  fl;
	logic        cin;
	logic        use_c;
	logic [8:0]  add9;
	logic [4:0]  addh;
	logic [8:0]  sub9;
	logic [4:0]  subh;
	logic [7:0]  alu_res;
	logic [3:0]  alu_flg;
	logic [7:0]  sh_res;
	logic        sh_c;
	logic [7:0]  mask;
	logic [7:0]  daa_res;
	logic        daa_c;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [16:0] w_sum;
	logic [12:0] w_h;
	logic [15:0] ofs_ext;
	logic [15:0] ofs_sum;
	logic [4:0]  ofs_h;
	logic [8:0]  ofs_c;

	assign a     = req.acc_value;
	assign v     = req.operand_value;
	assign fl    = req.flags_in;
	assign cin   = fl[FLAG_C];
	assign use_c = (req.req_type == OP_ADC || req.req_type == OP_SBC) ? cin : 1'b0;

	// Add and subtract with carry and half carry
	assign add9 = {1'b0, a} + {1'b0, v} + {8'd0, use_c};
	assign addh = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c};
	assign sub9 = {1'b0, a} - {1'b0, v} - {8'd0, use_c};
	assign subh = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c};

	// Accumulator ALU group
	always_comb begin
		alu_flg = 4'd0;
		unique case (req.req_type[2:0])
			AL_ADD, AL_ADC: begin
				alu_res         = add9[7:0];
				alu_flg[FLAG_H] = addh[4];
				alu_flg[FLAG_C] = add9[8];
			end
			AL_SUB, AL_SBC, AL_CP: begin
				alu_res         = sub9[7:0];
				alu_flg[FLAG_N] = 1'b1;
				alu_flg[FLAG_H] = subh[4];
				alu_flg[FLAG_C] = sub9[8];
			end
			AL_AND: begin
				alu_res         = a & v;
				alu_flg[FLAG_H] = 1'b1;
			end
			AL_XOR: alu_res = a ^ v;
			default: alu_res = a | v;
		endcase
		alu_flg[FLAG_Z] = (alu_res == 8'd0);
	end

	// Rotates and shifts
	always_comb begin
		unique case (req.req_type[2:0])
			SH_RLC:  begin sh_c = a[7]; sh_res = {a[6:0], a[7]}; end
			SH_RRC:  begin sh_c = a[0]; sh_res = {a[0], a[7:1]}; end
			SH_RL:   begin sh_c = a[7]; sh_res = {a[6:0], cin}; end
			SH_RR:   begin sh_c = a[0]; sh_res = {cin, a[7:1]}; end
			SH_SLA:  begin sh_c = a[7]; sh_res = {a[6:0], 1'b0}; end
			SH_SRA:  begin sh_c = a[0]; sh_res = {a[7], a[7:1]}; end
			SH_SWAP: begin sh_c = 1'b0; sh_res = {a[3:0], a[7:4]}; end
			default: begin sh_c = a[0]; sh_res = {1'b0, a[7:1]}; end
		endcase
	end

	// Decimal adjust after add or subtract
	always_comb begin
		logic [8:0] t1;
		logic [8:0] t2;
		logic       hi;
		t1 = 9'd0;
		t2 = 9'd0;
		hi = 1'b0;
		if (!fl[FLAG_N]) begin
			t1 = {1'b0, a} + ((fl[FLAG_H] || a[3:0] > 4'd9) ? 9'h006 : 9'h000);
			hi = fl[FLAG_C] || (t1 > 9'h09f);
			t2 = t1 + (hi ? 9'h060 : 9'h000);
			daa_res = t2[7:0];
			daa_c   = fl[FLAG_C] | hi;
		end else begin
			daa_res = a - (fl[FLAG_H] ? 8'h06 : 8'h00) - (fl[FLAG_C] ? 8'h60 : 8'h00);
			daa_c   = fl[FLAG_C];
		end
	end

	// Increment, decrement and wide adds
	assign mask    = 8'd1 << req.bit_index;
	assign inc8    = a + 8'd1;
	assign dec8    = a - 8'd1;
	assign w_sum   = {1'b0, req.wide_left} + {1'b0, req.wide_right};
	assign w_h     = {1'b0, req.wide_left[11:0]} + {1'b0, req.wide_right[11:0]};
	assign ofs_ext = {{8{req.signed_offset[7]}}, req.signed_offset};
	assign ofs_sum = req.wide_left + ofs_ext;
	assign ofs_h   = {1'b0, req.wide_left[3:0]} + {1'b0, req.signed_offset[3:0]};
	assign ofs_c   = {1'b0, req.wide_left[7:0]} + {1'b0, req.signed_offset[7:0]};

	// Select the result by operation group
	always_comb begin
		rsp.result_byte = a;
		rsp.result_word = 16'd0;
		rsp.flags_out   = fl;
		priority if (req.req_type <= OP_CP) begin
			rsp.result_byte = (req.req_type == OP_CP) ? a : alu_res;
			rsp.flags_out   = alu_flg;
		end else if (req.req_type <= OP_SRL) begin
			rsp.result_byte = sh_res;
			rsp.flags_out   = {(sh_res == 8'd0), 1'b0, 1'b0, sh_c};
		end else if (req.req_type <= OP_RRA) begin
			rsp.result_byte = sh_res;
			rsp.flags_out   = {1'b0, 1'b0, 1'b0, sh_c};
		end else begin
			unique case (req.req_type)
				OP_BIT: rsp.flags_out = {~|(a & mask), 1'b0, 1'b1, cin};
				OP_RES: rsp.result_byte = a & ~mask;
				OP_SET: rsp.result_byte = a | mask;
				OP_DAA: begin
					rsp.result_byte = daa_res;
					rsp.flags_out   = {(daa_res == 8'd0), fl[FLAG_N], 1'b0, daa_c};
				end
				OP_CPL: begin
					rsp.result_byte = ~a;
					rsp.flags_out   = {fl[FLAG_Z], 1'b1, 1'b1, cin};
				end
				OP_SCF: rsp.flags_out = {fl[FLAG_Z], 1'b0, 1'b0, 1'b1};
				OP_CCF: rsp.flags_out = {fl[FLAG_Z], 1'b0, 1'b0, ~cin};
				OP_INC8: begin
					rsp.result_byte = inc8;
					rsp.flags_out   = {(inc8 == 8'd0), 1'b0, (inc8[3:0] == 4'h0), cin};
				end
				OP_DEC8: begin
					rsp.result_byte = dec8;
					rsp.flags_out   = {(dec8 == 8'd0), 1'b1, (dec8[3:0] == 4'hf), cin};
				end
				OP_ADD16: begin
					rsp.result_byte = 8'd0;
					rsp.result_word = w_sum[15:0];
					rsp.flags_out   = {fl[FLAG_Z], 1'b0, w_h[12], w_sum[16]};
				end
				OP_ADDOFS: begin
					rsp.result_byte = 8'd0;
					rsp.result_word = ofs_sum;
					rsp.flags_out   = {1'b0, 1'b0, ofs_h[4], ofs_c[8]};
				end
				OP_INC16: begin
					rsp.result_byte = 8'd0;
					rsp.result_word = req.wide_left + 16'd1;
				end
				OP_DEC16: begin
					rsp.result_byte = 8'd0;
					rsp.result_word = req.wide_left - 16'd1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/cpu_alu_flag_unit.sv =====
// Top level of the ALU flag unit: input register, datapath, result register.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/req_stall | afu_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | afu_pkg::rsp_t
//
// One transaction per cycle is accepted while req_stall is low; it passes through the
// input register, then the result register.
// Reset clears both valid bits; payload registers are not reset.
// req_stall rises only when both registers are full and rsp_stall is high.
// A stalled result holds in the result register.
module cpu_alu_flag_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  afu_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output afu_pkg::rsp_t rsp_data
);
	import afu_pkg::*;

	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_s2;
	logic vld_s2;
	rsp_t core_rsp;
	logic adv_s2;
	logic adv_s1;

	// Advance when the downstream register is empty or draining
	assign adv_s2    = !vld_s2 || !rsp_stall;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign req_stall = !adv_s1;

	afu_core u_core (
		.req (req_s1),
		.rsp (core_rsp)
	);

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= req_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req_data;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp_data  = rsp_s2;

endmodule

// ===== rtl/afu_checker.sv =====
// Port-level checker for the ALU flag unit and its bind to the top level.
module afu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input afu_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input afu_pkg::rsp_t rsp_data
);
	import afu_pkg::*;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

	// Never stall input while the output side is empty
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("input stalled with empty output");

	// Deliver an accepted transaction through both registers when not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
		else $error("result missing after acceptance");

	// Check a 16-bit increment end to end
	a_inc16: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req_data.req_type == OP_INC16) ##1 !rsp_stall |=>
		rsp_data.result_word == 16'($past(req_data.wide_left, 2) + 16'd1) &&
		rsp_data.result_byte == 8'd0)
		else $error("wide increment result wrong");

endmodule

bind cpu_alu_flag_unit afu_checker u_afu_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the ALU flag unit: random and corner operations checked against a local predictor.
`timescale 1ns / 1ps

module tb;
	import afu_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_OPS   = 1400;
	localparam int HOLD_CYCLES  = 100;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req_data  = '0;
	logic  rsp_stall = 1'b0;
	logic  req_stall;
	logic  rsp_valid;
	rsp_t  rsp_data;

	req_t  ops_to_send[$];
	rsp_t  results_due[$];
	logic  req_taken   = 1'b0;
	logic  calm        = 1'b0;
	int    send_gap    = 0;
	int    recv_gap    = 0;
	int    hold_left   = 0;
	logic  hold_done   = 1'b0;
	int    ops_in      = 0;
	int    results_ok  = 0;
	int    errors      = 0;
	int    cycles      = 0;
	bit [63:0] codes_seen = '0;

	cpu_alu_flag_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #1 clk = ~clk;

	// Compute the byte result, word result and new flags of one operation
	function automatic rsp_t alu_result(req_t r);
		rsp_t       o;
		int         a, v, c, s, d, wl, wr, off;
		logic [3:0] fl, fo;
		logic [7:0] b, mask, ob;
		logic       nc;
		a    = r.acc_value;
		v    = r.operand_value;
		fl   = r.flags_in;
		c    = fl[FLAG_C];
		wl   = r.wide_left;
		wr   = r.wide_right;
		ob   = r.signed_offset;
		off  = ob;
		b    = r.acc_value;
		fo   = fl;
		mask = 8'h01 << r.bit_index;
		o.result_word = '0;
		if (r.req_type <= OP_CP) begin
			fo = '0;
			case (r.req_type)
				OP_ADD: begin
					s = a + v;
					fo[FLAG_H] = (a & 15) + (v & 15) > 15;
					fo[FLAG_C] = s > 255;
				end
				OP_ADC: begin
					s = a + v + c;
					fo[FLAG_H] = (a & 15) + (v & 15) + c > 15;
					fo[FLAG_C] = s > 255;
				end
				OP_SUB, OP_CP: begin
					s = a - v;
					fo[FLAG_N] = 1'b1;
					fo[FLAG_H] = (a & 15) < (v & 15);
					fo[FLAG_C] = a < v;
				end
				OP_SBC: begin
					s = a - v - c;
					fo[FLAG_N] = 1'b1;
					fo[FLAG_H] = (a & 15) < (v & 15) + c;
					fo[FLAG_C] = a < v + c;
				end
				OP_AND: begin
					s = a & v;
					fo[FLAG_H] = 1'b1;
				end
				OP_XOR: s = a ^ v;
				default: s = a | v;
			endcase
			fo[FLAG_Z] = (s & 255) == 0;
			// compare leaves the accumulator alone
			if (r.req_type != OP_CP)
				b = 8'(s);
		end else if (r.req_type <= OP_RRA) begin
			// CB rotates and shifts, then the accumulator rotates sharing the low bits
			fo = '0;
			case (r.req_type[2:0])
				SH_RLC: begin
					nc = b[7];
					b  = {b[6:0], b[7]};
				end
				SH_RRC: begin
					nc = b[0];
					b  = {b[0], b[7:1]};
				end
				SH_RL: begin
					nc = b[7];
					b  = {b[6:0], fl[FLAG_C]};
				end
				SH_RR: begin
					nc = b[0];
					b  = {fl[FLAG_C], b[7:1]};
				end
				SH_SLA: begin
					nc = b[7];
					b  = {b[6:0], 1'b0};
				end
				SH_SRA: begin
					nc = b[0];
					b  = {b[7], b[7:1]};
				end
				SH_SWAP: begin
					nc = 1'b0;
					b  = {b[3:0], b[7:4]};
				end
				default: begin
					nc = b[0];
					b  = {1'b0, b[7:1]};
				end
			endcase
			fo[FLAG_C] = nc;
			fo[FLAG_Z] = (b == 8'h00) && (r.req_type < OP_RLCA);
		end else begin
			case (r.req_type)
				OP_BIT: begin
					fo = '0;
					fo[FLAG_Z] = (b & mask) == 8'h00;
					fo[FLAG_H] = 1'b1;
					fo[FLAG_C] = fl[FLAG_C];
				end
				OP_RES: b = b & ~mask;
				OP_SET: b = b | mask;
				OP_DAA: begin
					fo = '0;
					fo[FLAG_N] = fl[FLAG_N];
					fo[FLAG_C] = fl[FLAG_C];
					d = a;
					if (!fl[FLAG_N]) begin
						if (fl[FLAG_H] || (d & 15) > 9)
							d = d + 'h06;
						if (fl[FLAG_C] || d > 'h9f) begin
							d = d + 'h60;
							fo[FLAG_C] = 1'b1;
						end
					end else begin
						if (fl[FLAG_H])
							d = (d - 'h06) & 255;
						if (fl[FLAG_C])
							d = d - 'h60;
					end
					b = 8'(d);
					fo[FLAG_Z] = b == 8'h00;
				end
				OP_CPL: begin
					b = ~b;
					fo[FLAG_N] = 1'b1;
					fo[FLAG_H] = 1'b1;
				end
				OP_SCF: begin
					fo = '0;
					fo[FLAG_Z] = fl[FLAG_Z];
					fo[FLAG_C] = 1'b1;
				end
				OP_CCF: begin
					fo = '0;
					fo[FLAG_Z] = fl[FLAG_Z];
					fo[FLAG_C] = ~fl[FLAG_C];
				end
				OP_INC8: begin
					b  = b + 8'd1;
					fo = '0;
					fo[FLAG_C] = fl[FLAG_C];
					fo[FLAG_Z] = b == 8'h00;
					fo[FLAG_H] = b[3:0] == 4'h0;
				end
				OP_DEC8: begin
					b  = b - 8'd1;
					fo = '0;
					fo[FLAG_C] = fl[FLAG_C];
					fo[FLAG_N] = 1'b1;
					fo[FLAG_Z] = b == 8'h00;
					fo[FLAG_H] = b[3:0] == 4'hf;
				end
				OP_ADD16: begin
					b = '0;
					s = wl + wr;
					o.result_word = 16'(s);
					fo = '0;
					fo[FLAG_Z] = fl[FLAG_Z];
					fo[FLAG_H] = (wl & 'hfff) + (wr & 'hfff) > 'hfff;
					fo[FLAG_C] = s > 'hffff;
				end
				OP_ADDOFS: begin
					// flags come from the unsigned low-byte add
					b = '0;
					o.result_word = r.wide_left + {{8{ob[7]}}, ob};
					fo = '0;
					fo[FLAG_H] = (wl & 15) + (off & 15) > 15;
					fo[FLAG_C] = (wl & 255) + off > 255;
				end
				OP_INC16: begin
					b = '0;
					o.result_word = r.wide_left + 16'd1;
				end
				OP_DEC16: begin
					b = '0;
					o.result_word = r.wide_left - 16'd1;
				end
				default: ;
			endcase
		end
		o.result_byte = b;
		o.flags_out   = fo;
		return o;
	endfunction

	// Bias a byte toward carry and borrow corners
	function automatic logic [7:0] pick_byte();
		logic [7:0] corners[7];
		corners = '{8'h00, 8'h01, 8'h0f, 8'h10, 8'h7f, 8'h80, 8'hff};
		if ($urandom_range(0, 3) == 0)
			return corners[$urandom_range(0, 6)];
		return 8'($urandom);
	endfunction

	function automatic req_t make_op(logic [5:0] code, logic [7:0] a, logic [7:0] v,
			logic [15:0] wl, logic [15:0] wr, logic [7:0] off, logic [2:0] bi,
			logic [3:0] fl);
		req_t r;
		r.req_type      = code;
		r.acc_value     = a;
		r.operand_value = v;
		r.wide_left     = wl;
		r.wide_right    = wr;
		r.signed_offset = off;
		r.bit_index     = bi;
		r.flags_in      = fl;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Observe both handshakes at the rising edge
	always @(posedge clk) begin : observe
		rsp_t want;
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: done, errors");
			$finish;
		end else begin
			req_taken <= req_valid && !req_stall;
			calm <= (ops_to_send.size() < 200) || ((ops_in / 128) % 4 == 3);
			if (req_valid && !req_stall) begin
				results_due.push_back(alu_result(req_data));
				codes_seen[req_data.req_type] <= 1'b1;
				ops_in <= ops_in + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: byte 0x%0h word 0x%0h flags 0x%0h",
						rsp_data.result_byte, rsp_data.result_word, rsp_data.flags_out);
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("result_byte", want.result_byte, rsp_data.result_byte);
					check_field("result_word", want.result_word, rsp_data.result_word);
					check_field("flags_out", want.flags_out, rsp_data.flags_out);
					results_ok <= results_ok + 1;
				end
			end
		end
	end

	// Offer the next transaction once the current one is taken
	always @(negedge clk) begin : drive_req
		logic offer;
		req_t item;
		int   gap;
		offer = req_valid;
		item  = req_data;
		gap   = send_gap;
		if (arst_n && (!req_valid || req_taken)) begin
			offer = 1'b0;
			if (gap > 0) begin
				gap--;
			end else if (ops_to_send.size() > 0) begin
				item  = ops_to_send.pop_front();
				offer = 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					gap = $urandom_range(1, 8);
			end
			send_gap <= gap;
		end
		req_valid <= offer;
		req_data  <= item;
	end

	// Hold off the result side for one long stretch to back up the pipe
	always @(negedge clk) begin : long_hold
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && ops_in >= 400) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Stall the result side in short random bursts
	always @(negedge clk) begin : drive_rsp
		logic stall;
		int   gap;
		stall = 1'b0;
		gap   = recv_gap;
		if (arst_n) begin
			if (hold_left > 0) begin
				stall = 1'b1;
			end else if (gap > 0) begin
				stall = 1'b1;
				gap--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = 1'b1;
				gap   = $urandom_range(0, 7);
			end
		end
		recv_gap  <= gap;
		rsp_stall <= stall;
	end

	// Build the stimulus, release reset and wait for the pipe to drain
	initial begin : stimulus
		logic       hi;
		logic [5:0] code;
		logic [7:0] fill;
		// every operation once, alternating all-ones and all-zeros operands
		for (int k = 0; k <= OP_DEC16; k++) begin
			hi   = k[0];
			fill = hi ? 8'hff : 8'h00;
			ops_to_send.push_back(make_op(6'(k), fill, fill, {fill, fill}, {fill, fill},
				hi ? 8'h80 : 8'h7f, hi ? 3'd7 : 3'd0, hi ? 4'hf : 4'h0));
		end
		// unused codes pass the accumulator and flags through
		ops_to_send.push_back(make_op(6'd33, 8'h5a, 8'ha5, 16'h1234, 16'h4321, 8'h01,
			3'd3, 4'h5));
		ops_to_send.push_back(make_op(6'd63, 8'ha5, 8'h5a, 16'hffff, 16'hffff, 8'hff,
			3'd5, 4'ha));
		// decimal adjust after add with overflow, after subtract with borrows
		ops_to_send.push_back(make_op(OP_DAA, 8'h9a, 8'h00, 16'h0, 16'h0, 8'h0, 3'd0, 4'h0));
		ops_to_send.push_back(make_op(OP_DAA, 8'h15, 8'h00, 16'h0, 16'h0, 8'h0, 3'd0, 4'h6));
		ops_to_send.push_back(make_op(OP_DAA, 8'h00, 8'h00, 16'h0, 16'h0, 8'h0, 3'd0, 4'h7));
		// wide adds: carry out of bit 11, low-byte carry with positive offset, negative offset
		ops_to_send.push_back(make_op(OP_ADD16, 8'h00, 8'h00, 16'h0fff, 16'h0001, 8'h0,
			3'd0, 4'h8));
		ops_to_send.push_back(make_op(OP_ADDOFS, 8'h00, 8'h00, 16'h00ff, 16'h0, 8'h01,
			3'd0, 4'hf));
		ops_to_send.push_back(make_op(OP_ADDOFS, 8'h00, 8'h00, 16'h0000, 16'h0, 8'hff,
			3'd0, 4'hf));

		// random operations, mostly defined codes
		repeat (RANDOM_OPS) begin
			if ($urandom_range(0, 9) == 0)
				code = 6'($urandom_range(33, 63));
			else
				code = 6'($urandom_range(0, 32));
			ops_to_send.push_back(make_op(code, pick_byte(), pick_byte(),
				{pick_byte(), pick_byte()}, {pick_byte(), pick_byte()}, pick_byte(),
				3'($urandom), 4'($urandom)));
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (ops_to_send.size() != 0 || req_valid || results_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("tb: %0d transactions sent, %0d results checked, %0d of 64 op codes seen",
			ops_in, results_ok, $countones(codes_seen));
		$display("tb: receiver hold-off of %0d cycles applied, %0d mismatches",
			HOLD_CYCLES, errors);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== cpu_alu_flag_unit.f =====
rtl/afu_pkg.sv
rtl/afu_core.sv
rtl/cpu_alu_flag_unit.sv
rtl/afu_checker.sv
tb/tb.sv
